// ===== rtl/mcq_pkg.sv =====
`default_nettype none

package mcq_pkg;

  // field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned WordW   = 8;
  localparam int unsigned PosW    = 6;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned OffW    = 8;
  localparam int unsigned MultW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 17;

  // datapath widths
  localparam int unsigned MagW   = SampleW;        // magnitude of -2048 still fits unsigned
  localparam int unsigned NumW   = MagW + 4;       // 16*mag + word
  localparam int unsigned ProdW  = NumW + MultW;
  localparam int unsigned ScaleShift = 17;
  localparam int unsigned SatW   = LevelW - 1;

  // divider organization: quotient bits resolved per pipeline stage
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned DivStages    = NumW / BitsPerStage;

  // register reset values
  localparam logic [OffW-1:0]  RoundOffsetRst = OffW'(1);
  localparam logic [MultW-1:0] MultiplierRst  = MultW'(65537);

  typedef enum logic {
    ModeIntra = 1'b0,
    ModeInter = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode        = 2'd0,
    RegRoundOffset = 2'd1,
    RegMultiplier  = 2'd2
  } cfg_reg_e;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic                      neg;       // sample was negative
    logic                      pass_dc;   // intra dc, sample goes out as is
    logic                      force_zero;
    logic                      err;       // intra divide by zero
    logic                      add_off;   // intra: add round offset after divide
    logic signed [SampleW-1:0] dc_val;
  } pipe_ctl_t;

  // restoring divider state
  typedef struct packed {
    logic [WordW-1:0] rem;
    logic [NumW-1:0]  dq;    // dividend shifting out, quotient shifting in
    logic [WordW-1:0] div;
  } div_state_t;

endpackage

`default_nettype wire

// ===== rtl/mcq_front.sv =====
`default_nettype none

module mcq_front
  import mcq_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire logic [WordW-1:0]          matrix_word_i,
  input  wire logic [PosW-1:0]           position_i,
  input  wire mode_e                     mode_i,
  output logic                           valid_o,
  output pipe_ctl_t                      ctl_o,
  output div_state_t                     div_o
);

  logic       valid_q;
  pipe_ctl_t  ctl_d, ctl_q;
  div_state_t div_d, div_q;

  always_comb begin
    logic            intra;
    logic [MagW-1:0] mag;
    logic [NumW-1:0] scaled;
    logic            zero;
    logic            dc;
    intra  = (mode_i == ModeIntra);
    mag    = sample_i[SampleW-1] ? (~sample_i + MagW'(1)) : sample_i;
    scaled = {mag, 4'b0000};
    zero   = (sample_i == '0);
    dc     = intra && (position_i == '0);

    ctl_d.neg        = sample_i[SampleW-1];
    ctl_d.pass_dc    = dc;
    ctl_d.err        = intra && !dc && !zero && (matrix_word_i == '0);
    ctl_d.force_zero = zero || ctl_d.err;
    ctl_d.add_off    = intra;
    ctl_d.dc_val     = sample_i;

    // inter mode divides by one so the sum passes the divider untouched
    div_d.rem = '0;
    if (intra) begin
      div_d.dq = scaled + NumW'(matrix_word_i >> 1);
    end else begin
      div_d.dq = scaled + NumW'(matrix_word_i);
    end
    div_d.div = (intra && (matrix_word_i != '0)) ? matrix_word_i : WordW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_d;
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// ===== rtl/mcq_div_stage.sv =====
`default_nettype none

module mcq_div_stage
  import mcq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire pipe_ctl_t  ctl_i,
  input  wire div_state_t div_i,
  output logic            valid_o,
  output pipe_ctl_t       ctl_o,
  output div_state_t      div_o
);

  logic       valid_q;
  pipe_ctl_t  ctl_q;
  div_state_t div_d, div_q;

  // restoring division, a few quotient bits per stage
  always_comb begin
    logic [WordW:0] trial;
    div_d = div_i;
    for (int unsigned b = 0; b < BitsPerStage; b++) begin
      trial    = {div_d.rem, div_d.dq[NumW-1]};
      div_d.dq = {div_d.dq[NumW-2:0], 1'b0};
      if (trial >= {1'b0, div_d.div}) begin
        trial       = trial - {1'b0, div_d.div};
        div_d.dq[0] = 1'b1;
      end
      div_d.rem = trial[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_i;
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// ===== rtl/mcq_scale.sv =====
`default_nettype none

module mcq_scale
  import mcq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire pipe_ctl_t                ctl_i,
  input  wire logic [NumW-1:0]          quot_i,
  input  wire logic [OffW-1:0]          round_offset_i,
  input  wire logic [MultW-1:0]         multiplier_i,
  output logic                          valid_o,
  output logic signed [LevelW-1:0]      level_o,
  output logic                          divide_error_o
);

  // offset add
  logic                    add_valid_q;
  pipe_ctl_t               add_ctl_q;
  logic [NumW-1:0]         sum_d, sum_q;
  // multiply
  logic                    mul_valid_q;
  pipe_ctl_t               mul_ctl_q;
  logic [ProdW-1:0]        prod;
  logic [NumW-1:0]         scaled_d, scaled_q;
  // saturate and sign
  logic                    out_valid_q;
  logic [SatW-1:0]         sat;
  logic signed [LevelW-1:0] level_d, level_q;
  logic                    err_q;

  function automatic logic [SatW-1:0] scaled_d_sat(input logic [NumW-1:0] v);
    return v[NumW-1] ? {SatW{1'b1}} : v[SatW-1:0];
  endfunction

  assign sum_d = quot_i + (ctl_i.add_off ? NumW'(round_offset_i) : NumW'(0));

  assign prod     = ProdW'(sum_q) * ProdW'(multiplier_i);
  assign scaled_d = prod[ProdW-1:ScaleShift];

  always_comb begin
    sat = scaled_d_sat(scaled_q);
    priority if (mul_ctl_q.pass_dc) begin
      level_d = LevelW'(mul_ctl_q.dc_val);
    end else if (mul_ctl_q.force_zero) begin
      level_d = '0;
    end else if (mul_ctl_q.neg) begin
      level_d = LevelW'(0) - LevelW'(sat);
    end else begin
      level_d = LevelW'(sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      add_valid_q <= valid_i;
      mul_valid_q <= add_valid_q;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    add_ctl_q <= ctl_i;
    sum_q     <= sum_d;
    mul_ctl_q <= add_ctl_q;
    scaled_q  <= scaled_d;
    level_q   <= level_d;
    err_q     <= mul_ctl_q.err;
  end

  assign valid_o        = out_valid_q;
  assign level_o        = level_q;
  assign divide_error_o = err_q;

endmodule

`default_nettype wire

// ===== rtl/matrix_coefficient_quantizer_unit.sv =====
`default_nettype none

// Matrix-weighted quantizer for DCT coefficients. One coefficient is taken at
// every clock edge where start_i is high; busy_o stays low, so the unit never
// refuses an item. Each item gives exactly one result on level_o and
// divide_error_o, marked by a one-cycle done_o strobe; results come out in
// input order and there is no output stall, the receiver must take every
// strobed result. Throughput is one item per cycle; the pipeline is a front
// stage, the divider, an 8-stage restoring array resolving two quotient bits
// per stage, and three scale stages (offset add, 16x17 multiply, saturate and
// sign). Intra mode divides 16*|sample| + word/2 by the matrix word, adds
// round_offset and scales by multiplier >> 17; inter mode scales
// 16*|sample| + word. Intra dc (position 0) passes the sample through; a zero
// intra word on a nonzero sample gives level 0 with divide_error_o set.
// Registers are written through cfg_we_i at any edge and must only change
// while no item is in flight.

module matrix_coefficient_quantizer_unit
  import mcq_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // item in
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire logic [WordW-1:0]          matrix_word_i,
  input  wire logic [PosW-1:0]           position_i,
  // result out
  output logic                           done_o,
  output logic signed [LevelW-1:0]       level_o,
  output logic                           divide_error_o,
  // register writes
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [CfgW-1:0]           cfg_wdata_i
);

  // configuration registers
  mode_e            mode_q;
  logic [OffW-1:0]  round_offset_q;
  logic [MultW-1:0] multiplier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ModeIntra;
      round_offset_q <= RoundOffsetRst;
      multiplier_q   <= MultiplierRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegMode:        mode_q         <= mode_e'(cfg_wdata_i[0]);
        RegRoundOffset: round_offset_q <= cfg_wdata_i[OffW-1:0];
        RegMultiplier:  multiplier_q   <= cfg_wdata_i[MultW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // the pipeline never stalls, so every start is taken
  assign busy_o = 1'b0;

  // stage 0 is the front end, stages 1..DivStages are the divider
  logic       pipe_valid [DivStages+1];
  pipe_ctl_t  pipe_ctl   [DivStages+1];
  div_state_t pipe_div   [DivStages+1];

  // sign split, numerator and divisor setup, special-case flags
  mcq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i),
    .sample_i      (sample_i),
    .matrix_word_i (matrix_word_i),
    .position_i    (position_i),
    .mode_i        (mode_q),
    .valid_o       (pipe_valid[0]),
    .ctl_o         (pipe_ctl[0]),
    .div_o         (pipe_div[0])
  );

  // restoring divider, a couple of quotient bits per stage
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    mcq_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pipe_valid[s]),
      .ctl_i   (pipe_ctl[s]),
      .div_i   (pipe_div[s]),
      .valid_o (pipe_valid[s+1]),
      .ctl_o   (pipe_ctl[s+1]),
      .div_o   (pipe_div[s+1])
    );
  end

  // offset, multiply, saturate and sign restore
  mcq_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (pipe_valid[DivStages]),
    .ctl_i          (pipe_ctl[DivStages]),
    .quot_i         (pipe_div[DivStages].dq),
    .round_offset_i (round_offset_q),
    .multiplier_i   (multiplier_q),
    .valid_o        (done_o),
    .level_o        (level_o),
    .divide_error_o (divide_error_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_matrix_coefficient_quantizer_unit.sv =====
`timescale 1ns / 100ps

module tb_matrix_coefficient_quantizer_unit;
  import mcq_pkg::*;

  localparam int unsigned LevelMax   = (1 << SatW) - 1;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned Phases     = 8;
  localparam int unsigned PhaseItems = 175;
  localparam int unsigned CalmItems  = 200;   // no sender gaps over the tail of the run
  localparam int unsigned TailCycles = 24;
  localparam int unsigned NumDirRows = 24;

  // one quantized coefficient as it leaves the block
  typedef struct packed {
    logic signed [LevelW-1:0] level;
    logic                     err;
  } quant_t;

  // directed stimulus row: setting, coefficient, and a typed-in answer where obvious
  typedef struct packed {
    mode_e                     mode;
    logic [OffW-1:0]           off;
    logic [MultW-1:0]          mult;
    logic signed [SampleW-1:0] smp;
    logic [WordW-1:0]          wd;
    logic [PosW-1:0]           pos;
    logic                      known;
    logic signed [LevelW-1:0]  lvl;
    logic                      err;
  } coeff_row_t;

  localparam coeff_row_t DirRows [NumDirRows] = '{
    // reset setting: intra, offset 1, multiplier 65537
    '{ModeIntra, 8'd1, 17'd65537, 12'sd2047, 8'd16, 6'd0, 1'b1, 16'sd2047, 1'b0},   // dc passes
    '{ModeIntra, 8'd1, 17'd65537, -12'sd2048, 8'd0, 6'd0, 1'b1, -16'sd2048, 1'b0},  // dc, zero word
    '{ModeIntra, 8'd1, 17'd65537, 12'sd0, 8'd255, 6'd0, 1'b1, 16'sd0, 1'b0},
    '{ModeIntra, 8'd1, 17'd65537, 12'sd0, 8'd0, 6'd5, 1'b1, 16'sd0, 1'b0},          // zero sample wins
    '{ModeIntra, 8'd1, 17'd65537, 12'sd100, 8'd0, 6'd1, 1'b1, 16'sd0, 1'b1},        // divide by zero
    '{ModeIntra, 8'd1, 17'd65537, -12'sd2048, 8'd0, 6'd63, 1'b1, 16'sd0, 1'b1},
    '{ModeIntra, 8'd1, 17'd65537, -12'sd1, 8'd255, 6'd63, 1'b0, 16'sd0, 1'b0},
    '{ModeIntra, 8'd1, 17'd65537, 12'sd2047, 8'd1, 6'd17, 1'b0, 16'sd0, 1'b0},
    '{ModeIntra, 8'd1, 17'd65537, -12'sd2048, 8'd1, 6'd42, 1'b0, 16'sd0, 1'b0},
    '{ModeIntra, 8'd1, 17'd65537, 12'sd1234, 8'd16, 6'd7, 1'b0, 16'sd0, 1'b0},
    // largest offset and multiplier: magnitude saturates
    '{ModeIntra, 8'd255, 17'd131071, -12'sd2048, 8'd1, 6'd1, 1'b1, -16'sd32767, 1'b0},
    '{ModeIntra, 8'd255, 17'd131071, 12'sd2047, 8'd1, 6'd2, 1'b1, 16'sd32767, 1'b0},
    '{ModeIntra, 8'd255, 17'd131071, 12'sd5, 8'd255, 6'd3, 1'b0, 16'sd0, 1'b0},
    // zero offset and multiplier
    '{ModeIntra, 8'd0, 17'd0, 12'sd2047, 8'd8, 6'd9, 1'b1, 16'sd0, 1'b0},
    '{ModeIntra, 8'd0, 17'd0, -12'sd2048, 8'd0, 6'd9, 1'b1, 16'sd0, 1'b1},
    // inter: position 0 is scaled like any other
    '{ModeInter, 8'd1, 17'd65537, 12'sd1000, 8'd40, 6'd0, 1'b0, 16'sd0, 1'b0},
    '{ModeInter, 8'd1, 17'd65537, 12'sd0, 8'd255, 6'd0, 1'b1, 16'sd0, 1'b0},
    '{ModeInter, 8'd1, 17'd65537, -12'sd2048, 8'd255, 6'd63, 1'b0, 16'sd0, 1'b0},
    '{ModeInter, 8'd1, 17'd65537, 12'sd2047, 8'd0, 6'd10, 1'b0, 16'sd0, 1'b0},
    '{ModeInter, 8'd1, 17'd65537, 12'sd1, 8'd0, 6'd4, 1'b0, 16'sd0, 1'b0},
    '{ModeInter, 8'd1, 17'd131071, -12'sd2048, 8'd255, 6'd0, 1'b1, -16'sd32767, 1'b0},
    '{ModeInter, 8'd1, 17'd131071, 12'sd2047, 8'd0, 6'd31, 1'b0, 16'sd0, 1'b0},
    '{ModeInter, 8'd1, 17'd0, -12'sd5, 8'd9, 6'd3, 1'b1, 16'sd0, 1'b0},
    // intra again, half-scale multiplier with no offset
    '{ModeIntra, 8'd0, 17'd65536, 12'sd33, 8'd8, 6'd12, 1'b0, 16'sd0, 1'b0}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic signed [SampleW-1:0] sample_i;
  logic [WordW-1:0]          matrix_word_i;
  logic [PosW-1:0]           position_i;
  logic                      done_o;
  logic signed [LevelW-1:0]  level_o;
  logic                      divide_error_o;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgW-1:0]           cfg_wdata_i;

  // shadow of the block's registers
  mode_e            cur_mode;
  logic [OffW-1:0]  cur_off;
  logic [MultW-1:0] cur_mult;

  quant_t pending_levels[$];
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned cycle_cnt    = 0;

  matrix_coefficient_quantizer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_i       (sample_i),
    .matrix_word_i  (matrix_word_i),
    .position_i     (position_i),
    .done_o         (done_o),
    .level_o        (level_o),
    .divide_error_o (divide_error_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // expected level for one coefficient under the current register setting
  function automatic quant_t quantize_coeff(logic signed [SampleW-1:0] smp,
                                            logic [WordW-1:0] wd, logic [PosW-1:0] pos);
    quant_t          res;
    int              s32;
    longint unsigned mag;
    longint unsigned q;
    s32 = smp;
    res.level = '0;
    res.err   = 1'b0;
    if (cur_mode == ModeIntra && pos == '0) begin
      // intra dc goes out untouched, sign-extended
      res.level = {{(LevelW-SampleW){smp[SampleW-1]}}, smp};
    end else if (s32 != 0) begin
      mag = (s32 < 0) ? longint'(-s32) : longint'(s32);
      if (cur_mode == ModeIntra) begin
        if (wd == '0) begin
          res.err = 1'b1;
          q = 0;
        end else begin
          // truncating divide, then offset and fixed-point scale
          q = ((mag << 4) + (wd >> 1)) / wd;
          q = ((q + cur_off) * cur_mult) >> ScaleShift;
        end
      end else begin
        q = (((mag << 4) + wd) * cur_mult) >> ScaleShift;
      end
      if (q > LevelMax) q = LevelMax;
      res.level = LevelW'(q);
      if (s32 < 0) res.level = -res.level;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR: result %0d: %s is %0d, expected %0d", result_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // results cannot be held off: take each strobed one at the edge that ends it
  always @(posedge clk_i) begin
    quant_t want;
    if (rst_ni && done_o) begin
      if (pending_levels.size() == 0) begin
        $display("ERROR: result %0d arrived with no item pending", result_cnt);
        mismatch_cnt++;
      end else begin
        want = pending_levels.pop_front();
        if (level_o !== want.level)
          report_mismatch("level", $signed(level_o), $signed(want.level));
        if (divide_error_o !== want.err)
          report_mismatch("divide_error", divide_error_o, want.err);
      end
      result_cnt++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one item: raise start at the falling edge, hold until an edge sees busy low
  task automatic send_coeff(logic signed [SampleW-1:0] smp, logic [WordW-1:0] wd,
                            logic [PosW-1:0] pos, quant_t want);
    @(negedge clk_i);
    start_i       <= 1'b1;
    sample_i      <= smp;
    matrix_word_i <= wd;
    position_i    <= pos;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_levels.push_back(want);
  endtask

  task automatic rest_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // stop sending and let every item in flight come out
  task automatic finish_pending();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
  endtask

  // write all three registers on consecutive edges, block idle
  task automatic load_setting(mode_e m, logic [OffW-1:0] o, logic [MultW-1:0] mu);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegMode;
    cfg_wdata_i <= CfgW'(m);
    @(negedge clk_i);
    cfg_index_i <= RegRoundOffset;
    cfg_wdata_i <= CfgW'(o);
    @(negedge clk_i);
    cfg_index_i <= RegMultiplier;
    cfg_wdata_i <= CfgW'(mu);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
    cur_off  = o;
    cur_mult = mu;
  endtask

  initial begin
    coeff_row_t                row;
    quant_t                    want;
    logic signed [SampleW-1:0] smp;
    logic [WordW-1:0]          wd;
    logic [PosW-1:0]           pos;
    logic [OffW-1:0]           off;
    logic [MultW-1:0]          mult;
    bit                        gaps_on;
    int unsigned               item_no;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    sample_i      = '0;
    matrix_word_i = '0;
    position_i    = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegMode;
    cfg_wdata_i   = '0;
    cur_mode      = ModeIntra;
    cur_off       = RoundOffsetRst;
    cur_mult      = MultiplierRst;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table; the first rows run on the reset values of the registers
    for (int i = 0; i < NumDirRows; i++) begin
      row = DirRows[i];
      if (row.mode != cur_mode || row.off != cur_off || row.mult != cur_mult) begin
        finish_pending();
        load_setting(row.mode, row.off, row.mult);
      end
      if (row.known) begin
        want.level = row.lvl;
        want.err   = row.err;
      end else begin
        want = quantize_coeff(row.smp, row.wd, row.pos);
      end
      send_coeff(row.smp, row.wd, row.pos, want);
    end

    // random phases, each under its own register setting
    item_no = 0;
    gaps_on = 1'b0;
    for (int p = 0; p < Phases; p++) begin
      finish_pending();
      // early phases pin offset and multiplier at their extremes
      case (p)
        0: off = '0;
        1: off = '1;
        default: off = OffW'($urandom_range(0, 255));
      endcase
      case (p)
        2: mult = '0;
        3: mult = '1;
        4: mult = MultW'($urandom_range(0, 4095));
        default: mult = MultW'($urandom_range(0, 131071));
      endcase
      load_setting(p[0] ? ModeInter : ModeIntra, off, mult);
      for (int k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(0, 7))
          0: begin
            case ($urandom_range(0, 4))
              0: smp = -12'sd2048;
              1: smp = 12'sd2047;
              2: smp = 12'sd0;
              3: smp = -12'sd1;
              default: smp = 12'sd1;
            endcase
          end
          1, 2: smp = SampleW'(int'($urandom_range(0, 64)) - 32);
          default: smp = SampleW'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: wd = '0;
          1: wd = 8'd1;
          2: wd = '1;
          default: wd = WordW'($urandom);
        endcase
        pos = ($urandom_range(0, 5) == 0) ? '0 : PosW'($urandom);

        // sender gaps come in stretches, none near the end of the run
        if (item_no % 32 == 0) gaps_on = $urandom_range(0, 1);
        if (gaps_on && item_no < Phases * PhaseItems - CalmItems
            && $urandom_range(0, 2) == 0)
          rest_sender($urandom_range(1, 10));

        send_coeff(smp, wd, pos, quantize_coeff(smp, wd, pos));
        item_no++;
      end
    end

    finish_pending();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
